@@ rtl/assert_macros.svh @@
// Assertion macros shared by the slot remap RTL.
// Assertions compile only when SYNTHESIS is not defined; otherwise they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SWSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SWSR_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SWSR_ASSERT(label, clk, rst, prop, msg)
`define SWSR_NEVER(label, clk, rst, cond, msg)
`endif

`endif

@@ rtl/swsr_pkg.sv @@
// Shared constants, types and helper functions for the sliding window slot remap unit.
// No dependencies.
package swsr_pkg;

   localparam int RADIUS       = 1;
   localparam int CHUNK_EDGE   = 16;   // power of two, 2..256
   localparam int SIDE         = 2 * RADIUS + 1;
   localparam int SLOTS        = SIDE * SIDE * SIDE;
   localparam int COORD_W      = 20;
   localparam int POS_W        = 32;
   localparam int FRAC_BITS    = 8;
   localparam int CHUNK_SHIFT  = FRAC_BITS + $clog2(CHUNK_EDGE);
   localparam int IDX_W        = $clog2(SLOTS + 1);
   localparam int OFS_W        = $clog2(SIDE + 1);
   localparam int SLOT_FIELD_W = 5;
   localparam int ORIGIN_W     = 3 * COORD_W;
   localparam int REQ_DATA_W   = 3 * POS_W;
   localparam int RSP_DATA_W   = 8 * ((SLOT_FIELD_W + ORIGIN_W + 7) / 8);

   // x in the low bits
   typedef struct packed {
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } coord_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_DRAIN,
      ST_ASSIGN
   } fsm_state_type;

   // floor(pos / (256 * CHUNK_EDGE)) wrapped to COORD_W bits
   function automatic logic [COORD_W-1:0] to_chunk(input logic [POS_W-1:0] pos);
      logic signed [POS_W-1:0] q;
      q = $signed(pos) >>> CHUNK_SHIFT;
      return q[COORD_W-1:0];
   endfunction

   // lowest set bit index
   function automatic logic [IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (v[k]) r = IDX_W'(k);
      end
      return r;
   endfunction

endpackage

@@ rtl/swsr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module swsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sliding_window_slot_remap_unit.sv @@
// Sliding window slot remap unit. Each request word carries a world position
// (three signed Q.8 values); the unit floors it to a chunk origin and keeps a
// cube of (2R+1)^3 slots, each tagged with a chunk coordinate, in a RAM. A word
// whose origin equals the current one (after the first word since reset)
// produces nothing. A new origin starts a recenter: every window position is
// compared against every slot, one position-slot pair per cycle through the
// RAM read port (SLOTS*SLOTS pairs, 729 at R=1), then a drain state, then one
// window position per cycle to hand each unmatched position the lowest free
// slot and emit a response word; an unmatched position waits while rsp_tready
// holds the output back. req_tready is high only between recenters. Response
// words carry the slot index and its new chunk coordinate; tlast marks the
// final word of a recenter.
// Depends on swsr_pkg, swsr_ram and assert_macros.svh.
`include "assert_macros.svh"

module sliding_window_slot_remap_unit (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [swsr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: slot_index [4:0], chunk_x [24:5], chunk_y [44:25],
   //            chunk_z [64:45], zero fill [71:65]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [swsr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int SLOTS   = swsr_pkg::SLOTS;
   localparam int IDX_W   = swsr_pkg::IDX_W;
   localparam int OFS_W   = swsr_pkg::OFS_W;
   localparam int COORD_W = swsr_pkg::COORD_W;
   localparam int POS_W   = swsr_pkg::POS_W;

   localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [OFS_W-1:0]   LAST_OFS = OFS_W'(swsr_pkg::SIDE - 1);
   localparam logic [COORD_W-1:0] RAD_C    = COORD_W'(swsr_pkg::RADIUS);

   // control state
   swsr_pkg::fsm_state_type state_ff, state_in;
   logic                    known_ff, known_in;
   swsr_pkg::coord_type     origin_ff, origin_in;
   logic [SLOTS-1:0]        valid_ff, valid_in;     // slot holds a chunk
   logic [SLOTS-1:0]        pending_ff, pending_in; // window position unmatched
   logic [SLOTS-1:0]        free_ff, free_in;       // slot unclaimed this recenter

   // window position walk (z innermost) and slot scan
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [OFS_W-1:0]        dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;

   // compare stage, lines up with the RAM read data
   logic                    cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]        cmp_pos_ff, cmp_pos_in;
   logic [IDX_W-1:0]        cmp_slot_ff, cmp_slot_in;
   swsr_pkg::coord_type     cmp_win_ff, cmp_win_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_slot_ff, rsp_slot_in;
   swsr_pkg::coord_type     rsp_win_ff, rsp_win_in;
   logic                    rsp_last_ff, rsp_last_in;

   swsr_pkg::coord_type     win;
   swsr_pkg::coord_type     req_origin;
   swsr_pkg::coord_type     ram_rd_data;
   logic [IDX_W-1:0]        free_slot;
   logic                    assign_fire;
   logic                    req_fire;
   logic                    out_room;
   logic [SLOTS-1:0]        pending_upper;

   // current window coordinate, wraps at COORD_W bits
   assign win.x = origin_ff.x + COORD_W'(dx_ff) - RAD_C;
   assign win.y = origin_ff.y + COORD_W'(dy_ff) - RAD_C;
   assign win.z = origin_ff.z + COORD_W'(dz_ff) - RAD_C;

   assign req_origin.x = swsr_pkg::to_chunk(req_tdata[POS_W-1:0]);
   assign req_origin.y = swsr_pkg::to_chunk(req_tdata[2*POS_W-1:POS_W]);
   assign req_origin.z = swsr_pkg::to_chunk(req_tdata[3*POS_W-1:2*POS_W]);

   assign req_tready    = (state_ff == swsr_pkg::ST_IDLE);
   assign req_fire      = req_tvalid & req_tready;
   assign out_room      = ~rsp_valid_ff | rsp_tready;
   assign free_slot     = swsr_pkg::lowest_set(free_ff);
   assign pending_upper = (pending_ff >> pos_ff) >> 1;
   assign assign_fire   = (state_ff == swsr_pkg::ST_ASSIGN) & pending_ff[pos_ff] & out_room;

   swsr_ram #(
      .WIDTH (swsr_pkg::ORIGIN_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (assign_fire),
      .wr_addr (free_slot),
      .wr_data (win),
      .rd_en   (state_ff == swsr_pkg::ST_MATCH),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic advance;
      advance      = 1'b0;
      state_in     = state_ff;
      known_in     = known_ff;
      origin_in    = origin_ff;
      valid_in     = valid_ff;
      pending_in   = pending_ff;
      free_in      = free_ff;
      pos_in       = pos_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      slot_in      = slot_ff;
      cmp_valid_in = 1'b0;
      cmp_pos_in   = pos_ff;
      cmp_slot_in  = slot_ff;
      cmp_win_in   = win;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_last_in  = rsp_last_ff;

      // compare stage: first valid slot matching a still-pending position
      if (cmp_valid_ff && valid_ff[cmp_slot_ff] && ram_rd_data == cmp_win_ff &&
          pending_ff[cmp_pos_ff]) begin
         pending_in[cmp_pos_ff] = 1'b0;
         free_in[cmp_slot_ff]   = 1'b0;
      end

      case (state_ff)
         swsr_pkg::ST_IDLE: begin
            if (req_fire && !(known_ff && req_origin == origin_ff)) begin
               origin_in  = req_origin;
               known_in   = 1'b1;
               pending_in = '1;
               free_in    = '1;
               state_in   = swsr_pkg::ST_MATCH;
            end
         end
         swsr_pkg::ST_MATCH: begin
            cmp_valid_in = 1'b1;
            if (slot_ff == LAST_IDX) begin
               slot_in = '0;
               advance = 1'b1;
            end else begin
               slot_in = IDX_W'(slot_ff + 1'b1);
            end
         end
         swsr_pkg::ST_DRAIN: begin
            state_in = swsr_pkg::ST_ASSIGN;
         end
         swsr_pkg::ST_ASSIGN: begin
            if (assign_fire) begin
               valid_in[free_slot]  = 1'b1;
               pending_in[pos_ff]   = 1'b0;
               free_in[free_slot]   = 1'b0;
               rsp_valid_in         = 1'b1;
               rsp_slot_in          = free_slot;
               rsp_win_in           = win;
               rsp_last_in          = (pending_upper == '0);
            end
            advance = ~pending_ff[pos_ff] | assign_fire;
         end
         default: begin
            state_in = swsr_pkg::ST_IDLE;
         end
      endcase

      // step to the next window position; wrap ends the current pass
      if (advance) begin
         if (pos_ff == LAST_IDX) begin
            pos_in   = '0;
            dx_in    = '0;
            dy_in    = '0;
            dz_in    = '0;
            state_in = (state_ff == swsr_pkg::ST_MATCH) ? swsr_pkg::ST_DRAIN
                                                        : swsr_pkg::ST_IDLE;
         end else begin
            pos_in = IDX_W'(pos_ff + 1'b1);
            if (dz_ff == LAST_OFS) begin
               dz_in = '0;
               if (dy_ff == LAST_OFS) begin
                  dy_in = '0;
                  dx_in = OFS_W'(dx_ff + 1'b1);
               end else begin
                  dy_in = OFS_W'(dy_ff + 1'b1);
               end
            end else begin
               dz_in = OFS_W'(dz_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swsr_pkg::ST_IDLE;
         known_ff     <= 1'b0;
         origin_ff    <= '0;
         valid_ff     <= '0;
         pending_ff   <= '0;
         free_ff      <= '0;
         pos_ff       <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         dz_ff        <= '0;
         slot_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         known_ff     <= known_in;
         origin_ff    <= origin_in;
         valid_ff     <= valid_in;
         pending_ff   <= pending_in;
         free_ff      <= free_in;
         pos_ff       <= pos_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         dz_ff        <= dz_in;
         slot_ff      <= slot_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cmp_pos_ff  <= cmp_pos_in;
      cmp_slot_ff <= cmp_slot_in;
      cmp_win_ff  <= cmp_win_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = swsr_pkg::RSP_DATA_W'({rsp_win_ff,
                                              swsr_pkg::SLOT_FIELD_W'(rsp_slot_ff)});

   // every window position is placed by the end of a recenter
   `SWSR_ASSERT(a_idle_no_pending, clock, reset, (state_ff == swsr_pkg::ST_IDLE) |-> (pending_ff == '0), "pending positions left in idle")
   // matches and assignments always retire one position and one slot together
   `SWSR_ASSERT(a_pending_free_balance, clock, reset, (state_ff == swsr_pkg::ST_ASSIGN) |-> ($countones(pending_ff) == $countones(free_ff)), "pending and free counts differ")
   // compare results only arrive while matching or draining
   `SWSR_ASSERT(a_cmp_in_match, clock, reset, cmp_valid_ff |-> (state_ff == swsr_pkg::ST_MATCH || state_ff == swsr_pkg::ST_DRAIN), "compare stage active outside match")
   // a slot is only rewritten if it is still unclaimed
   `SWSR_NEVER(a_write_claimed_slot, clock, reset, assign_fire && !free_ff[free_slot], "write to a claimed slot")

endmodule
